/* design/ihj_pkg.sv */
// Package for the implicit heat step Jacobi core: grid geometry, codes,
// state encoding and small arithmetic helpers. No dependencies.
`default_nettype none
package ihj_pkg;

  localparam int GRID_ORDER = 32;
  localparam int CELL_COUNT = GRID_ORDER * GRID_ORDER;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int COORD_W    = $clog2(GRID_ORDER);
  localparam int IT_W       = CELL_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [24:0] ONE_Q24 = 25'd16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEIGHBOUR_GAIN = 3'd0,
    REG_SELF_GAIN      = 3'd1,
    REG_RELAX_WEIGHT   = 3'd2,
    REG_TOLERANCE_SQ   = 3'd3,
    REG_MAX_SWEEPS     = 3'd4,
    REG_PROBE_ROW      = 3'd5,
    REG_PROBE_COL      = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_LIMIT      = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_MUL1, S_SAT1, S_MUL2, S_SAT2, S_DIFF, S_SQ, S_ACC,
    S_SWEEP_END, S_COPY, S_COPY_TAIL, S_PROBE_RD, S_PROBE_WAIT, S_DONE
  } state_e;

  // Raster address of a grid cell
  function automatic logic [CELL_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    logic [CELL_W-1:0] a;
    a = CELL_W'(CELL_W'(row) * CELL_W'(GRID_ORDER)) + CELL_W'(col);
    return a;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] y;
    if (x > 40'sh007FFFFFFF) y = 32'sh7FFFFFFF;
    else if (x < -40'sh0080000000) y = 32'sh80000000;
    else y = x[31:0];
    return y;
  endfunction

endpackage
`default_nettype wire

/* design/ihj_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module ihj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* design/implicit_heat_step_jacobi_core.sv */
// Implicit heat step by weighted Jacobi sweeps, five-point stencil, Q8.24.
// Load beats: one per cycle while idle. Run beat: each sweep visits every interior cell
// in seven read slots on the single read port, then seven arithmetic steps,
// followed by a sweep-end step; then a copy pass over the interior cells,
// and a probe read before the result beat.
// Reset clears load pointer, loaded flag, control state and registers to
// their defaults; the cell stores are undefined until loaded.
`default_nettype none
module implicit_heat_step_jacobi_core import ihj_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  operation_i,
  input  wire logic signed [31:0]    cell_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [31:0]         probe_value_o,
  output logic [15:0]                sweeps_used_o,
  output logic [1:0]                 status_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [24:0] ng_q, sg_q, rw_q;
  logic [47:0] tol_q;
  logic [15:0] max_q;
  logic [4:0]  prow_q, pcol_q;

  logic [CELL_W-1:0]  ptr_q;
  logic               loaded_q;
  logic [2:0]         rs_q;
  logic               sel_q;
  logic [COORD_W-1:0] i_q, j_q;
  logic signed [33:0] sum4_q;
  logic signed [31:0] old_q, prev_q, in32_q, nv_q, res_val_q;
  logic signed [59:0] m1_q;
  logic signed [57:0] m2_q, m3_q, m4_q;
  logic signed [32:0] d_q;
  logic [63:0]        sq_q, acc_q;
  logic [15:0]        cnt_q;
  logic               conv_q, np_q;
  logic               cp_pend_q;
  logic [CELL_W-1:0]  cp_addr_q;

  logic               in_acc, last_cell, use_lvl, bnd, sweep_done;
  logic [COORD_W-1:0] rd_row, rd_col, pr, pc;
  logic [24:0]        r_eff;
  logic [15:0]        lim;
  logic [16:0]        cnt_inc;
  logic signed [31:0] cap;
  logic [32:0]        ad;
  logic [64:0]        acc_sum;

  logic              lvl_we;
  logic [CELL_W-1:0] lvl_waddr, lvl_raddr;
  logic [31:0]       lvl_wdata, lvl_rdata;
  logic              it_we;
  logic [IT_W-1:0]   it_waddr, it_raddr;
  logic [31:0]       it_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign r_eff      = (rw_q > ONE_Q24) ? ONE_Q24 : rw_q;
  assign lim        = (max_q == 16'd0) ? 16'd1 : max_q;
  assign cnt_inc    = {1'b0, cnt_q} + 17'd1;
  assign last_cell  = (32'(i_q) == GRID_ORDER - 2) && (32'(j_q) == GRID_ORDER - 2);
  assign cap        = sel_q ? $signed(lvl_rdata) : $signed(it_rdata);
  assign ad         = d_q[32] ? 33'(-d_q) : 33'(d_q);
  assign acc_sum    = {1'b0, acc_q} + {1'b0, sq_q};
  assign sweep_done = (acc_q < {16'd0, tol_q}) || (cnt_inc[15:0] == lim);
  assign pr = (32'(prow_q) >= GRID_ORDER) ? COORD_W'(GRID_ORDER - 1) : COORD_W'(prow_q);
  assign pc = (32'(pcol_q) >= GRID_ORDER) ? COORD_W'(GRID_ORDER - 1) : COORD_W'(pcol_q);

  // Pick the stencil tap for the current read slot
  always_comb begin
    rd_row = i_q;
    rd_col = j_q;
    bnd    = 1'b0;
    case (rs_q)
      3'd0: begin
        rd_row = i_q - COORD_W'(1);
        bnd    = (rd_row == '0);
      end
      3'd1: begin
        rd_col = j_q - COORD_W'(1);
        bnd    = (rd_col == '0);
      end
      3'd3: begin
        rd_col = j_q + COORD_W'(1);
        bnd    = (32'(rd_col) == GRID_ORDER - 1);
      end
      3'd4: begin
        rd_row = i_q + COORD_W'(1);
        bnd    = (32'(rd_row) == GRID_ORDER - 1);
      end
      default: ;
    endcase
    use_lvl = (rs_q == 3'd5) || (cnt_q == 16'd0) || bnd;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i) state_d = loaded_q ? S_READ : S_DONE;
      end
      S_READ:       if (rs_q == 3'd6) state_d = S_MUL1;
      S_MUL1:       state_d = S_SAT1;
      S_SAT1:       state_d = S_MUL2;
      S_MUL2:       state_d = S_SAT2;
      S_SAT2:       state_d = S_DIFF;
      S_DIFF:       state_d = S_SQ;
      S_SQ:         state_d = S_ACC;
      S_ACC:        state_d = last_cell ? S_SWEEP_END : S_READ;
      S_SWEEP_END:  state_d = sweep_done ? S_COPY : S_READ;
      S_COPY:       if (last_cell) state_d = S_COPY_TAIL;
      S_COPY_TAIL:  state_d = S_PROBE_RD;
      S_PROBE_RD:   state_d = S_PROBE_WAIT;
      S_PROBE_WAIT: state_d = S_DONE;
      S_DONE:       if (!out_valid_o || out_ready_i) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    lvl_we    = 1'b0;
    lvl_waddr = ptr_q;
    lvl_wdata = cell_value_i;
    lvl_raddr = cell_addr(rd_row, rd_col);
    it_we     = 1'b0;
    it_waddr  = {cnt_q[0], cell_addr(i_q, j_q)};
    it_raddr  = {~cnt_q[0], cell_addr(rd_row, rd_col)};
    case (state_q)
      S_IDLE: lvl_we = in_acc && !operation_i;
      S_DIFF: it_we  = 1'b1;
      S_COPY, S_COPY_TAIL: begin
        lvl_we    = cp_pend_q;
        lvl_waddr = cp_addr_q;
        lvl_wdata = it_rdata;
        it_raddr  = {~cnt_q[0], cell_addr(i_q, j_q)};
      end
      S_PROBE_RD: lvl_raddr = cell_addr(pr, pc);
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ng_q   <= 25'd4194304;
      sg_q   <= '0;
      rw_q   <= '0;
      tol_q  <= 48'd3;
      max_q  <= 16'd1000;
      prow_q <= 5'd5;
      pcol_q <= 5'd5;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NEIGHBOUR_GAIN: ng_q   <= cfg_data_i[24:0];
        REG_SELF_GAIN:      sg_q   <= cfg_data_i[24:0];
        REG_RELAX_WEIGHT:   rw_q   <= cfg_data_i[24:0];
        REG_TOLERANCE_SQ:   tol_q  <= cfg_data_i[47:0];
        REG_MAX_SWEEPS:     max_q  <= cfg_data_i[15:0];
        REG_PROBE_ROW:      prow_q <= cfg_data_i[4:0];
        REG_PROBE_COL:      pcol_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      loaded_q    <= 1'b0;
      rs_q        <= '0;
      i_q         <= COORD_W'(1);
      j_q         <= COORD_W'(1);
      cnt_q       <= '0;
      conv_q      <= 1'b0;
      np_q        <= 1'b0;
      cp_pend_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      // Raise the result beat when the slot is free, drop it once taken
      if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          rs_q <= '0;
          i_q  <= COORD_W'(1);
          j_q  <= COORD_W'(1);
          if (in_acc && !operation_i) begin
            if (32'(ptr_q) == CELL_COUNT - 1) begin
              ptr_q    <= '0;
              loaded_q <= 1'b1;
            end else begin
              ptr_q <= ptr_q + CELL_W'(1);
            end
          end
          if (in_acc && operation_i) begin
            cnt_q <= '0;
            np_q  <= !loaded_q;
          end
        end
        S_READ: rs_q <= (rs_q == 3'd6) ? 3'd0 : rs_q + 3'd1;
        S_ACC, S_COPY: begin
          // Advance the raster walk over interior cells
          if (last_cell) begin
            i_q <= COORD_W'(1);
            j_q <= COORD_W'(1);
          end else if (32'(j_q) == GRID_ORDER - 2) begin
            j_q <= COORD_W'(1);
            i_q <= i_q + COORD_W'(1);
          end else begin
            j_q <= j_q + COORD_W'(1);
          end
          if (state_q == S_COPY) cp_pend_q <= 1'b1;
        end
        S_SWEEP_END: begin
          cnt_q  <= cnt_inc[15:0];
          conv_q <= (acc_q < {16'd0, tol_q});
        end
        S_COPY_TAIL: cp_pend_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Datapath: gather taps, two multiply stages, difference, square, accumulate and probe capture
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: acc_q <= '0;
      S_READ: begin
        sel_q <= use_lvl;
        if (rs_q == 3'd0) sum4_q <= '0;
        case (rs_q)
          3'd1, 3'd2, 3'd4, 3'd5: sum4_q <= sum4_q + 34'(cap);
          3'd3: old_q  <= cap;
          3'd6: prev_q <= cap;
          default: ;
        endcase
      end
      S_MUL1: begin
        m1_q <= $signed({1'b0, ng_q}) * sum4_q;
        m2_q <= $signed({1'b0, sg_q}) * prev_q;
      end
      S_SAT1: in32_q <= sat32(40'(m1_q >>> 24) + 40'(m2_q >>> 24));
      S_MUL2: begin
        m3_q <= $signed({1'b0, r_eff}) * old_q;
        m4_q <= $signed({1'b0, 25'(ONE_Q24 - r_eff)}) * in32_q;
      end
      S_SAT2: nv_q <= sat32(40'(m3_q >>> 24) + 40'(m4_q >>> 24));
      S_DIFF: d_q  <= 33'(nv_q) - 33'(old_q);
      S_SQ:   sq_q <= ad[31:0] * ad[31:0];
      S_ACC:  acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
      S_SWEEP_END: if (!sweep_done) acc_q <= '0;
      S_COPY: cp_addr_q <= cell_addr(i_q, j_q);
      S_PROBE_WAIT: res_val_q <= lvl_rdata;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
      probe_value_o <= np_q ? '0 : res_val_q;
      sweeps_used_o <= np_q ? '0 : cnt_q;
      status_o      <= np_q ? ST_NOT_LOADED : (conv_q ? ST_CONVERGED : ST_LIMIT);
    end
  end

  ihj_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_level (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  ihj_ram #(.WIDTH(32), .DEPTH(2 * CELL_COUNT)) u_iter (
    .clk_i   (clk_i),
    .we_i    (it_we),
    .waddr_i (it_waddr),
    .wdata_i (nv_q),
    .raddr_i (it_raddr),
    .rdata_o (it_rdata)
  );

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < CELL_COUNT) else $error("load pointer out of range");
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && state_q != S_DONE |-> cnt_q <= lim) else $error("sweep overrun");
  a_rs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_q <= 3'd6) else $error("read slot out of range");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3) else $error("bad status code");
  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE_RD |-> !cp_pend_q) else $error("copy write still pending");

endmodule
`default_nettype wire
